### src/plca_pkg.sv
// ----------------------------------------------------------------------------
// plca_pkg
// Shared constants, state codes and arithmetic helpers for the polyline
// closest-point and look-ahead block.
// ----------------------------------------------------------------------------
package plca_pkg;

  localparam int PATH_POINTS = 64;
  localparam int IDX_W       = $clog2(PATH_POINTS);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [63:0]        DIST_BOUND = 64'd100000 << 32;
  localparam logic signed [32:0] FAR_POS    = 33'sd33554432;
  localparam logic signed [32:0] FAR_NEG    = -33'sd33554432;
  localparam logic [63:0]        SQ_TOP_BIT = 64'd1 << 62;
  localparam logic [6:0]         PROJ_STEPS = 7'd30;
  localparam logic [6:0]         ALONG_STEPS = 7'd64;
  localparam logic [5:0]         SQRT_STEPS = 6'd32;

  localparam logic CFG_LAD  = 1'b0;
  localparam logic CFG_PLEN = 1'b1;

  localparam int ST_W = 39;

  typedef enum logic [ST_W-1:0] {
    ST_IDLE = 39'b1 << 0,
    ST_ONEA = 39'b1 << 1,
    ST_ONEB = 39'b1 << 2,
    ST_RDA  = 39'b1 << 3,
    ST_RDB  = 39'b1 << 4,
    ST_SEG  = 39'b1 << 5,
    ST_L1   = 39'b1 << 6,
    ST_L2   = 39'b1 << 7,
    ST_D1   = 39'b1 << 8,
    ST_D2   = 39'b1 << 9,
    ST_CMP  = 39'b1 << 10,
    ST_DIV  = 39'b1 << 11,
    ST_PX   = 39'b1 << 12,
    ST_PY   = 39'b1 << 13,
    ST_PC   = 39'b1 << 14,
    ST_DIST = 39'b1 << 15,
    ST_Q1   = 39'b1 << 16,
    ST_Q2   = 39'b1 << 17,
    ST_Q3   = 39'b1 << 18,
    ST_NXT  = 39'b1 << 19,
    ST_WA   = 39'b1 << 20,
    ST_WB   = 39'b1 << 21,
    ST_WC   = 39'b1 << 22,
    ST_VL1  = 39'b1 << 23,
    ST_VL2  = 39'b1 << 24,
    ST_VL3  = 39'b1 << 25,
    ST_VL4  = 39'b1 << 26,
    ST_SQ   = 39'b1 << 27,
    ST_VLD  = 39'b1 << 28,
    ST_KA   = 39'b1 << 29,
    ST_KB   = 39'b1 << 30,
    ST_KC   = 39'b1 << 31,
    ST_AX0  = 39'b1 << 32,
    ST_AX1  = 39'b1 << 33,
    ST_AXD  = 39'b1 << 34,
    ST_AY0  = 39'b1 << 35,
    ST_AY1  = 39'b1 << 36,
    ST_AYD  = 39'b1 << 37,
    ST_OUT  = 39'b1 << 38
  } state_t;

  typedef enum logic [1:0] {
    VP_FIRST = 2'd0,
    VP_SEG   = 2'd1,
    VP_DIR   = 2'd2
  } vphase_t;

  typedef enum logic [1:0] {
    DM_PROJ = 2'd0,
    DM_ALX  = 2'd1,
    DM_ALY  = 2'd2
  } dmode_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic signed [30:0] shr_mag(input logic signed [32:0] v,
                                                 input logic [1:0] s);
    logic [32:0] m;
    m = mag33(v) >> s;
    return v[32] ? -$signed(31'(m)) : $signed(31'(m));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (v > 41'sd2147483647) return 32'sh7fffffff;
    if (v < -41'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] proj_axis(input logic signed [31:0] start,
                                                   input logic neg,
                                                   input logic [32:0] m);
    logic signed [33:0] s34;
    logic signed [33:0] mm;
    logic signed [33:0] r;
    s34 = {{2{start[31]}}, start};
    mm  = $signed({1'b0, m});
    r   = neg ? s34 - mm : s34 + mm;
    return r[31:0];
  endfunction

  function automatic logic signed [40:0] along_add(input logic signed [31:0] base,
                                                   input logic neg,
                                                   input logic [39:0] m);
    logic signed [40:0] b;
    logic signed [40:0] mm;
    b  = {{9{base[31]}}, base};
    mm = $signed({1'b0, m});
    return neg ? b - mm : b + mm;
  endfunction

endpackage

### src/polyline_closest_and_lookahead.sv
// ----------------------------------------------------------------------------
// polyline_closest_and_lookahead
// Closest point on a stored polyline and look-ahead point along it.
//
// Input stream: tuser is the opcode (0 stores a path point, 1 runs a query).
// A store transfer writes one slot and returns nothing. A query scans every
// segment through one shared multiplier and a bit-serial divider, then walks
// the path by the look-ahead distance with a bit-serial square root.
// Config writes (look-ahead distance, path length) are to go in while idle;
// the block itself does not enforce this. A segment whose projection clamps
// to an end skips the divider; one that does not needs the 30-step quotient.
// Each length taken in the walk uses the 32-step root, and the final scaling
// uses two 64-step quotients unless the walked length is zero.
// A single-point path skips the scan and walk. in_tready is low while a query
// runs; one result waits in the output register while the next item is taken.
// A stalled receiver holds the finished query until the register frees. Reset
// clears control state and the look-ahead distance and sets the path length
// and the remembered segment to one; path memory holds garbage until written.
// ----------------------------------------------------------------------------
module polyline_closest_and_lookahead (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // point_slot, coord_x, coord_y
  input  logic [0:0]   in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // target_x, target_y, nearest_x, nearest_y, segment_end
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  plca_pkg::state_t  state_r;
  plca_pkg::vphase_t ph_r;
  plca_pkg::dmode_t  dm_r;

  logic signed [31:0] mem_x [plca_pkg::PATH_POINTS];
  logic signed [31:0] mem_y [plca_pkg::PATH_POINTS];
  logic signed [31:0] rd_x_r, rd_y_r;
  logic [plca_pkg::IDX_W-1:0] rd_addr_c;

  logic signed [31:0] lx_r, ly_r, x0_r, y0_r, x1_r, y1_r, cx_r, cy_r, bx_r, by_r;
  logic signed [31:0] px_r, py_r, kx_r, ky_r, k1x_r, k1y_r, basex_r, basey_r;
  logic [plca_pkg::CNT_W-1:0] n_r, n_c, npc_c;
  logic [plca_pkg::IDX_W-1:0] i_r, np_r, k_r, best_r;
  logic signed [32:0] sx_r, sy_r, sgx_r, sgy_r, vx_r, vy_r;
  logic signed [30:0] qsx_r, qsy_r, qrx_r, qry_r;
  logic signed [63:0] acc_r, len2_r, dot_c;
  logic [63:0] bestd_r, d2_c;
  logic signed [25:0] dx_r, dy_r;
  logic [63:0] div_rem_r, div_den_r, div_num_r, div_q_r, div_rs_c;
  logic [6:0] div_cnt_r;
  logic [31:0] vax_r, vay_r;
  logic halve_r;
  logic [63:0] sq_v_r, sq_r_r, sq_b_r, sq_t_c;
  logic [5:0] sq_cnt_r;
  logic [33:0] len_r, vlen_c;
  logic signed [39:0] remw_r, rem_c;
  logic [30:0] amount_r;
  logic signed [40:0] tx_r, ty_r;
  logic [30:0] lad_r;
  logic [6:0] plen_r;
  logic out_valid_r;
  logic [135:0] out_data_r;
  logic signed [33:0] mul_a_c, mul_b_c;
  logic signed [67:0] prod_r;

  logic in_acc;
  logic in_op;
  logic [5:0] in_slot;
  logic signed [31:0] in_x, in_y;

  logic signed [32:0] sx_c, sy_c, rx_c, ry_c, dx_c, dy_c;
  logic [32:0] m_c, m01_c, m23_c, vmx_c, vmy_c;
  logic [1:0] s_c;

  assign in_op     = in_tuser[0];
  assign in_slot   = in_tdata[5:0];
  assign in_x      = in_tdata[37:6];
  assign in_y      = in_tdata[69:38];
  assign in_tready = (state_r == plca_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if (plen_r == 7'd0) n_c = plca_pkg::CNT_W'(1);
    else if (int'(plen_r) > plca_pkg::PATH_POINTS) n_c = plca_pkg::CNT_W'(plca_pkg::PATH_POINTS);
    else n_c = plca_pkg::CNT_W'(plen_r);
    npc_c = ({1'b0, best_r} > n_c - 1'b1) ? n_c - 1'b1 : {1'b0, best_r};
    if (npc_c == '0) npc_c = plca_pkg::CNT_W'(1);
  end

  always_comb begin
    sx_c  = $signed({rd_x_r[31], rd_x_r}) - $signed({x0_r[31], x0_r});
    sy_c  = $signed({rd_y_r[31], rd_y_r}) - $signed({y0_r[31], y0_r});
    rx_c  = $signed({lx_r[31], lx_r}) - $signed({x0_r[31], x0_r});
    ry_c  = $signed({ly_r[31], ly_r}) - $signed({y0_r[31], y0_r});
    m01_c = (plca_pkg::mag33(sx_c) > plca_pkg::mag33(sy_c)) ?
            plca_pkg::mag33(sx_c) : plca_pkg::mag33(sy_c);
    m23_c = (plca_pkg::mag33(rx_c) > plca_pkg::mag33(ry_c)) ?
            plca_pkg::mag33(rx_c) : plca_pkg::mag33(ry_c);
    m_c   = (m01_c > m23_c) ? m01_c : m23_c;
    if (m_c[32]) s_c = 2'd3;
    else if (m_c[31]) s_c = 2'd2;
    else if (m_c[30]) s_c = 2'd1;
    else s_c = 2'd0;
    dx_c  = $signed({cx_r[31], cx_r}) - $signed({lx_r[31], lx_r});
    dy_c  = $signed({cy_r[31], cy_r}) - $signed({ly_r[31], ly_r});
    dot_c = acc_r + prod_r[63:0];
    d2_c  = 64'(acc_r) + 64'(prod_r[63:0]);
    div_rs_c = {div_rem_r[62:0], div_num_r[63]};
    sq_t_c   = sq_r_r + sq_b_r;
    vlen_c   = halve_r ? {sq_r_r[32:0], 1'b0} : {1'b0, sq_r_r[32:0]};
    rem_c    = $signed({9'b0, lad_r}) - $signed({6'b0, vlen_c});
    vmx_c    = plca_pkg::mag33(vx_r);
    vmy_c    = plca_pkg::mag33(vy_r);
  end

  always_comb begin
    mul_a_c = '0;
    mul_b_c = '0;
    case (state_r)
      plca_pkg::ST_L1: begin
        mul_a_c = {{3{qsx_r[30]}}, qsx_r}; mul_b_c = {{3{qsx_r[30]}}, qsx_r};
      end
      plca_pkg::ST_L2: begin
        mul_a_c = {{3{qsy_r[30]}}, qsy_r}; mul_b_c = {{3{qsy_r[30]}}, qsy_r};
      end
      plca_pkg::ST_D1: begin
        mul_a_c = {{3{qsx_r[30]}}, qsx_r}; mul_b_c = {{3{qrx_r[30]}}, qrx_r};
      end
      plca_pkg::ST_D2: begin
        mul_a_c = {{3{qsy_r[30]}}, qsy_r}; mul_b_c = {{3{qry_r[30]}}, qry_r};
      end
      plca_pkg::ST_PX: begin
        mul_a_c = $signed({1'b0, plca_pkg::mag33(sx_r)});
        mul_b_c = $signed({4'b0, div_q_r[29:0]});
      end
      plca_pkg::ST_PY: begin
        mul_a_c = $signed({1'b0, plca_pkg::mag33(sy_r)});
        mul_b_c = $signed({4'b0, div_q_r[29:0]});
      end
      plca_pkg::ST_Q1: begin
        mul_a_c = {{8{dx_r[25]}}, dx_r}; mul_b_c = {{8{dx_r[25]}}, dx_r};
      end
      plca_pkg::ST_Q2: begin
        mul_a_c = {{8{dy_r[25]}}, dy_r}; mul_b_c = {{8{dy_r[25]}}, dy_r};
      end
      plca_pkg::ST_VL2: begin
        mul_a_c = $signed({2'b0, vax_r}); mul_b_c = $signed({2'b0, vax_r});
      end
      plca_pkg::ST_VL3: begin
        mul_a_c = $signed({2'b0, vay_r}); mul_b_c = $signed({2'b0, vay_r});
      end
      plca_pkg::ST_AX0: begin
        mul_a_c = $signed({1'b0, vmx_c}); mul_b_c = $signed({3'b0, amount_r});
      end
      plca_pkg::ST_AY0: begin
        mul_a_c = $signed({1'b0, vmy_c}); mul_b_c = $signed({3'b0, amount_r});
      end
      default: begin
        mul_a_c = '0;
        mul_b_c = '0;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      plca_pkg::ST_RDA: rd_addr_c = i_r;
      plca_pkg::ST_RDB: rd_addr_c = i_r + 1'b1;
      plca_pkg::ST_WA:  rd_addr_c = np_r;
      plca_pkg::ST_WB:  rd_addr_c = np_r - 1'b1;
      plca_pkg::ST_KA:  rd_addr_c = k_r;
      plca_pkg::ST_KB:  rd_addr_c = k_r + 1'b1;
      default:          rd_addr_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a_c * mul_b_c;
    rd_x_r <= mem_x[rd_addr_c];
    rd_y_r <= mem_y[rd_addr_c];
    if (in_acc && !in_op && int'(in_slot) < plca_pkg::PATH_POINTS) begin
      mem_x[plca_pkg::IDX_W'(in_slot)] <= in_x;
      mem_y[plca_pkg::IDX_W'(in_slot)] <= in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plca_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      lad_r       <= '0;
      plen_r      <= 7'd1;
      best_r      <= plca_pkg::IDX_W'(1);
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index[0])
          plca_pkg::CFG_LAD:  lad_r  <= cfg_data;
          plca_pkg::CFG_PLEN: plen_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && state_r != plca_pkg::ST_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        plca_pkg::ST_IDLE: begin
          if (in_acc && in_op) begin
            lx_r    <= in_x;
            ly_r    <= in_y;
            n_r     <= n_c;
            np_r    <= npc_c[plca_pkg::IDX_W-1:0];
            i_r     <= '0;
            bestd_r <= plca_pkg::DIST_BOUND;
            bx_r    <= '0;
            by_r    <= '0;
            state_r <= (n_c == plca_pkg::CNT_W'(1)) ? plca_pkg::ST_ONEA : plca_pkg::ST_RDA;
          end
        end
        plca_pkg::ST_ONEA: state_r <= plca_pkg::ST_ONEB;
        plca_pkg::ST_ONEB: begin
          tx_r    <= {{9{rd_x_r[31]}}, rd_x_r};
          ty_r    <= {{9{rd_y_r[31]}}, rd_y_r};
          bx_r    <= rd_x_r;
          by_r    <= rd_y_r;
          np_r    <= '0;
          state_r <= plca_pkg::ST_OUT;
        end
        plca_pkg::ST_RDA: state_r <= plca_pkg::ST_RDB;
        plca_pkg::ST_RDB: begin
          x0_r    <= rd_x_r;
          y0_r    <= rd_y_r;
          state_r <= plca_pkg::ST_SEG;
        end
        plca_pkg::ST_SEG: begin
          x1_r    <= rd_x_r;
          y1_r    <= rd_y_r;
          sx_r    <= sx_c;
          sy_r    <= sy_c;
          qsx_r   <= plca_pkg::shr_mag(sx_c, s_c);
          qsy_r   <= plca_pkg::shr_mag(sy_c, s_c);
          qrx_r   <= plca_pkg::shr_mag(rx_c, s_c);
          qry_r   <= plca_pkg::shr_mag(ry_c, s_c);
          state_r <= plca_pkg::ST_L1;
        end
        plca_pkg::ST_L1: state_r <= plca_pkg::ST_L2;
        plca_pkg::ST_L2: begin
          acc_r   <= prod_r[63:0];
          state_r <= plca_pkg::ST_D1;
        end
        plca_pkg::ST_D1: begin
          len2_r  <= acc_r + prod_r[63:0];
          state_r <= plca_pkg::ST_D2;
        end
        plca_pkg::ST_D2: begin
          acc_r   <= prod_r[63:0];
          state_r <= plca_pkg::ST_CMP;
        end
        plca_pkg::ST_CMP: begin
          if (len2_r == '0 || dot_c <= 0) begin
            cx_r    <= x0_r;
            cy_r    <= y0_r;
            state_r <= plca_pkg::ST_DIST;
          end else if (dot_c >= len2_r) begin
            cx_r    <= x1_r;
            cy_r    <= y1_r;
            state_r <= plca_pkg::ST_DIST;
          end else begin
            div_rem_r <= 64'(dot_c);
            div_num_r <= '0;
            div_den_r <= 64'(len2_r);
            div_q_r   <= '0;
            div_cnt_r <= plca_pkg::PROJ_STEPS;
            dm_r      <= plca_pkg::DM_PROJ;
            state_r   <= plca_pkg::ST_DIV;
          end
        end
        plca_pkg::ST_DIV: begin
          div_num_r <= {div_num_r[62:0], 1'b0};
          if (div_rs_c >= div_den_r) begin
            div_rem_r <= div_rs_c - div_den_r;
            div_q_r   <= {div_q_r[62:0], 1'b1};
          end else begin
            div_rem_r <= div_rs_c;
            div_q_r   <= {div_q_r[62:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == 7'd1) begin
            case (dm_r)
              plca_pkg::DM_PROJ: state_r <= plca_pkg::ST_PX;
              plca_pkg::DM_ALX:  state_r <= plca_pkg::ST_AXD;
              default:           state_r <= plca_pkg::ST_AYD;
            endcase
          end
        end
        plca_pkg::ST_PX: state_r <= plca_pkg::ST_PY;
        plca_pkg::ST_PY: begin
          cx_r    <= plca_pkg::proj_axis(x0_r, sx_r[32], prod_r[62:30]);
          state_r <= plca_pkg::ST_PC;
        end
        plca_pkg::ST_PC: begin
          cy_r    <= plca_pkg::proj_axis(y0_r, sy_r[32], prod_r[62:30]);
          state_r <= plca_pkg::ST_DIST;
        end
        plca_pkg::ST_DIST: begin
          dx_r <= dx_c[25:0];
          dy_r <= dy_c[25:0];
          if (dx_c >= plca_pkg::FAR_POS || dx_c <= plca_pkg::FAR_NEG ||
              dy_c >= plca_pkg::FAR_POS || dy_c <= plca_pkg::FAR_NEG) begin
            state_r <= plca_pkg::ST_NXT;
          end else begin
            state_r <= plca_pkg::ST_Q1;
          end
        end
        plca_pkg::ST_Q1: state_r <= plca_pkg::ST_Q2;
        plca_pkg::ST_Q2: begin
          acc_r   <= prod_r[63:0];
          state_r <= plca_pkg::ST_Q3;
        end
        plca_pkg::ST_Q3: begin
          if (d2_c < bestd_r) begin
            bestd_r <= d2_c;
            bx_r    <= cx_r;
            by_r    <= cy_r;
            np_r    <= i_r + 1'b1;
          end
          state_r <= plca_pkg::ST_NXT;
        end
        plca_pkg::ST_NXT: begin
          if (({1'b0, i_r} + plca_pkg::CNT_W'(2)) < n_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= plca_pkg::ST_RDA;
          end else begin
            best_r  <= np_r;
            state_r <= plca_pkg::ST_WA;
          end
        end
        plca_pkg::ST_WA: state_r <= plca_pkg::ST_WB;
        plca_pkg::ST_WB: begin
          px_r    <= rd_x_r;
          py_r    <= rd_y_r;
          state_r <= plca_pkg::ST_WC;
        end
        plca_pkg::ST_WC: begin
          sgx_r   <= $signed({px_r[31], px_r}) - $signed({rd_x_r[31], rd_x_r});
          sgy_r   <= $signed({py_r[31], py_r}) - $signed({rd_y_r[31], rd_y_r});
          vx_r    <= $signed({px_r[31], px_r}) - $signed({bx_r[31], bx_r});
          vy_r    <= $signed({py_r[31], py_r}) - $signed({by_r[31], by_r});
          ph_r    <= plca_pkg::VP_FIRST;
          state_r <= plca_pkg::ST_VL1;
        end
        plca_pkg::ST_VL1: begin
          if (vmx_c[32] || vmx_c[31] || vmy_c[32] || vmy_c[31]) begin
            halve_r <= 1'b1;
            vax_r   <= vmx_c[32:1];
            vay_r   <= vmy_c[32:1];
          end else begin
            halve_r <= 1'b0;
            vax_r   <= vmx_c[31:0];
            vay_r   <= vmy_c[31:0];
          end
          state_r <= plca_pkg::ST_VL2;
        end
        plca_pkg::ST_VL2: state_r <= plca_pkg::ST_VL3;
        plca_pkg::ST_VL3: begin
          acc_r   <= prod_r[63:0];
          state_r <= plca_pkg::ST_VL4;
        end
        plca_pkg::ST_VL4: begin
          sq_v_r   <= d2_c;
          sq_r_r   <= '0;
          sq_b_r   <= plca_pkg::SQ_TOP_BIT;
          sq_cnt_r <= plca_pkg::SQRT_STEPS;
          state_r  <= plca_pkg::ST_SQ;
        end
        plca_pkg::ST_SQ: begin
          if (sq_v_r >= sq_t_c) begin
            sq_v_r <= sq_v_r - sq_t_c;
            sq_r_r <= (sq_r_r >> 1) + sq_b_r;
          end else begin
            sq_r_r <= sq_r_r >> 1;
          end
          sq_b_r   <= sq_b_r >> 2;
          sq_cnt_r <= sq_cnt_r - 1'b1;
          if (sq_cnt_r == 6'd1) state_r <= plca_pkg::ST_VLD;
        end
        plca_pkg::ST_VLD: begin
          case (ph_r)
            plca_pkg::VP_FIRST: begin
              if (rem_c > 0) begin
                remw_r   <= rem_c;
                amount_r <= rem_c[30:0];
                k_r      <= np_r;
                if (({1'b0, np_r} + plca_pkg::CNT_W'(1)) < n_r) begin
                  state_r <= plca_pkg::ST_KA;
                end else begin
                  basex_r <= px_r;
                  basey_r <= py_r;
                  vx_r    <= sgx_r;
                  vy_r    <= sgy_r;
                  ph_r    <= plca_pkg::VP_DIR;
                  state_r <= plca_pkg::ST_VL1;
                end
              end else begin
                amount_r <= lad_r;
                basex_r  <= bx_r;
                basey_r  <= by_r;
                vx_r     <= sgx_r;
                vy_r     <= sgy_r;
                ph_r     <= plca_pkg::VP_DIR;
                state_r  <= plca_pkg::ST_VL1;
              end
            end
            plca_pkg::VP_SEG: begin
              if (remw_r <= $signed({6'b0, vlen_c})) begin
                amount_r <= remw_r[30:0];
                basex_r  <= kx_r;
                basey_r  <= ky_r;
                ph_r     <= plca_pkg::VP_DIR;
                state_r  <= plca_pkg::ST_VL1;
              end else begin
                remw_r <= remw_r - $signed({6'b0, vlen_c});
                k_r    <= k_r + 1'b1;
                if (({1'b0, k_r} + plca_pkg::CNT_W'(2)) < n_r) begin
                  state_r <= plca_pkg::ST_KA;
                end else begin
                  basex_r <= k1x_r;
                  basey_r <= k1y_r;
                  len_r   <= '0;
                  state_r <= plca_pkg::ST_AX0;
                end
              end
            end
            default: begin
              len_r   <= vlen_c;
              state_r <= plca_pkg::ST_AX0;
            end
          endcase
        end
        plca_pkg::ST_KA: state_r <= plca_pkg::ST_KB;
        plca_pkg::ST_KB: begin
          kx_r    <= rd_x_r;
          ky_r    <= rd_y_r;
          state_r <= plca_pkg::ST_KC;
        end
        plca_pkg::ST_KC: begin
          k1x_r   <= rd_x_r;
          k1y_r   <= rd_y_r;
          vx_r    <= $signed({rd_x_r[31], rd_x_r}) - $signed({kx_r[31], kx_r});
          vy_r    <= $signed({rd_y_r[31], rd_y_r}) - $signed({ky_r[31], ky_r});
          ph_r    <= plca_pkg::VP_SEG;
          state_r <= plca_pkg::ST_VL1;
        end
        plca_pkg::ST_AX0: begin
          if (len_r == '0) begin
            tx_r    <= {{9{basex_r[31]}}, basex_r};
            state_r <= plca_pkg::ST_AY0;
          end else begin
            state_r <= plca_pkg::ST_AX1;
          end
        end
        plca_pkg::ST_AX1: begin
          div_rem_r <= '0;
          div_num_r <= prod_r[63:0];
          div_den_r <= {30'b0, len_r};
          div_q_r   <= '0;
          div_cnt_r <= plca_pkg::ALONG_STEPS;
          dm_r      <= plca_pkg::DM_ALX;
          state_r   <= plca_pkg::ST_DIV;
        end
        plca_pkg::ST_AXD: begin
          tx_r    <= plca_pkg::along_add(basex_r, vx_r[32], div_q_r[39:0]);
          state_r <= plca_pkg::ST_AY0;
        end
        plca_pkg::ST_AY0: begin
          if (len_r == '0) begin
            ty_r    <= {{9{basey_r[31]}}, basey_r};
            state_r <= plca_pkg::ST_OUT;
          end else begin
            state_r <= plca_pkg::ST_AY1;
          end
        end
        plca_pkg::ST_AY1: begin
          div_rem_r <= '0;
          div_num_r <= prod_r[63:0];
          div_den_r <= {30'b0, len_r};
          div_q_r   <= '0;
          div_cnt_r <= plca_pkg::ALONG_STEPS;
          dm_r      <= plca_pkg::DM_ALY;
          state_r   <= plca_pkg::ST_DIV;
        end
        plca_pkg::ST_AYD: begin
          ty_r    <= plca_pkg::along_add(basey_r, vy_r[32], div_q_r[39:0]);
          state_r <= plca_pkg::ST_OUT;
        end
        plca_pkg::ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {2'b0, 6'(np_r), by_r, bx_r,
                            plca_pkg::sat32(ty_r), plca_pkg::sat32(tx_r)};
            out_valid_r <= 1'b1;
            state_r     <= plca_pkg::ST_IDLE;
          end
        end
        default: state_r <= plca_pkg::ST_IDLE;
      endcase
    end
  end

  a_div_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plca_pkg::ST_DIV) |-> (div_rem_r < div_den_r && div_cnt_r != '0))
    else $error("divider remainder not below divisor");

  a_walk_index_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plca_pkg::ST_WA) |-> (np_r != '0 && {1'b0, np_r} < n_r))
    else $error("remembered segment end outside path");

  a_loop_seg_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plca_pkg::ST_KA) |-> (({1'b0, k_r} + plca_pkg::CNT_W'(1)) < n_r))
    else $error("walk segment beyond path end");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plca_pkg::ST_OUT && (!out_valid_r || out_tready)) |=>
      (out_valid_r && state_r == plca_pkg::ST_IDLE))
    else $error("finished query not loaded into output register");

endmodule
